FILE: hdl/sen_pkg.sv
// ----------------------------------------------------------------------------
// sen_pkg: shared types and constants of the scaled euclidean norm block
// Arithmetic opcodes, command record and state encodings used by the
// sequencer and the serial floating-point unit.
// ----------------------------------------------------------------------------
package sen_pkg;

  // fp32 and bf16 constants
  localparam logic [31:0] FP_ZERO = 32'h0000_0000;
  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_INF  = 32'h7F80_0000;
  localparam logic [15:0] BF_ZERO = 16'h0000;
  localparam logic [15:0] BF_INF  = 16'h7F80;
  localparam logic [15:0] BF_QNAN = 16'h7FC0;

  // operations of the serial arithmetic unit
  typedef enum logic [1:0] {
    FOP_MUL,
    FOP_DIV,
    FOP_ADD,
    FOP_SQRT
  } fop_t;

  // one command for the arithmetic unit
  typedef struct packed {
    fop_t        op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_cmd_t;

  // arithmetic unit states
  typedef enum logic [3:0] {
    F_IDLE,
    F_PREN,
    F_MUL,
    F_DIV,
    F_ALIGN,
    F_SQRT,
    F_NORM,
    F_DENORM,
    F_ROUND
  } fpu_state_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_SQ,
    S_PROD,
    S_ACC,
    S_FIN,
    S_ROOT,
    S_SCALE,
    S_OUT
  } seq_state_t;

endpackage

FILE: hdl/sen_fpu.sv
// ----------------------------------------------------------------------------
// sen_fpu: serial fp32 arithmetic unit
// Multiply, divide, add and square root on positive finite fp32 operands,
// one bit of the significand per cycle, with a shared serial normalize and
// round-to-nearest-even pack stage that supports subnormal results.
// ----------------------------------------------------------------------------
module sen_fpu import sen_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  fpu_cmd_t    cmd,
  output logic        done,
  output logic [31:0] result
);

  fpu_state_t         state_r, state_nxt;
  logic [23:0]        ma_r, ma_nxt, mb_r, mb_nxt;
  logic signed [10:0] ea_r, ea_nxt, eb_r, eb_nxt;
  logic [49:0]        r_r, r_nxt, sm_r, sm_nxt;
  logic signed [10:0] e_r, e_nxt;
  logic               s_r, s_nxt;
  logic [26:0]        rem_r, rem_nxt;
  logic [26:0]        q_r, q_nxt;
  logic [47:0]        n_r, n_nxt;
  logic [5:0]         cnt_r, cnt_nxt;

  // operand unpack
  logic [23:0]        sig_a, sig_b;
  logic signed [10:0] exp_a, exp_b;
  logic signed [10:0] dif, mag;
  logic [5:0]         dif_cap;

  // square root setup
  logic               sq_odd;
  logic signed [10:0] sq_e0, sq_eadj;
  logic [24:0]        sq_m;

  // iteration datapaths
  logic [24:0]        mul_sum;
  logic               div_ge;
  logic [26:0]        div_rem;
  logic [26:0]        sq_st, sq_trial, sq_rem;
  logic               sq_ge;
  logic [23:0]        sq_root;

  // rounding
  logic [23:0]        rnd_mant;
  logic               rnd_up;
  logic [10:0]        rnd_em1;
  logic [33:0]        rnd_val;

  always_comb begin
    sig_a = {|cmd.a[30:23], cmd.a[22:0]};
    sig_b = {|cmd.b[30:23], cmd.b[22:0]};
    exp_a = (cmd.a[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, cmd.a[30:23]});
    exp_b = (cmd.b[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, cmd.b[30:23]});
    dif     = exp_a - exp_b;
    mag     = dif[10] ? -dif : dif;
    dif_cap = (mag > 11'sd63) ? 6'd63 : mag[5:0];

    // odd unbiased exponent moves one bit into the significand
    sq_odd  = ~cmd.a[23];
    sq_e0   = exp_a - 11'sd127;
    sq_eadj = sq_odd ? sq_e0 - 11'sd1 : sq_e0;
    sq_m    = sq_odd ? {sig_a, 1'b0} : {1'b0, sig_a};

    mul_sum = {1'b0, r_r[49:26]} + (r_r[2] ? {1'b0, ma_r} : 25'd0);

    div_ge  = rem_r >= {3'b000, mb_r};
    div_rem = div_ge ? rem_r - {3'b000, mb_r} : rem_r;

    sq_st    = {rem_r[24:0], n_r[47:46]};
    sq_trial = {1'b0, q_r[23:0], 2'b01};
    sq_ge    = sq_st >= sq_trial;
    sq_rem   = sq_ge ? sq_st - sq_trial : sq_st;
    sq_root  = {q_r[22:0], sq_ge};

    rnd_mant = r_r[48:25];
    rnd_up   = r_r[24] & ((|r_r[23:0]) | s_r | rnd_mant[0]);
    rnd_em1  = e_r - 11'sd1;
    rnd_val  = {rnd_em1, 23'd0} + {10'd0, rnd_mant} + {33'd0, rnd_up};
    result   = (rnd_val >= {2'b00, FP_INF}) ? FP_INF : rnd_val[31:0];
    done     = (state_r == F_ROUND);
  end

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    ea_nxt    = ea_r;
    eb_nxt    = eb_r;
    r_nxt     = r_r;
    sm_nxt    = sm_r;
    e_nxt     = e_r;
    s_nxt     = s_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    n_nxt     = n_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          ma_nxt = sig_a;
          mb_nxt = sig_b;
          ea_nxt = exp_a;
          eb_nxt = exp_b;
          s_nxt  = 1'b0;
          q_nxt  = 27'd0;
          case (cmd.op)
            FOP_MUL: begin
              r_nxt     = {24'd0, sig_b, 2'b00};
              e_nxt     = exp_a + exp_b - 11'sd127;
              cnt_nxt   = 6'd23;
              state_nxt = F_MUL;
            end
            FOP_DIV: begin
              state_nxt = F_PREN;
            end
            FOP_ADD: begin
              // larger exponent goes to the accumulator
              if (dif[10]) begin
                r_nxt  = {1'b0, sig_b, 25'd0};
                sm_nxt = {1'b0, sig_a, 25'd0};
                e_nxt  = exp_b;
              end else begin
                r_nxt  = {1'b0, sig_a, 25'd0};
                sm_nxt = {1'b0, sig_b, 25'd0};
                e_nxt  = exp_a;
              end
              cnt_nxt   = dif_cap;
              state_nxt = F_ALIGN;
            end
            FOP_SQRT: begin
              n_nxt     = {sq_m, 23'd0};
              e_nxt     = (sq_eadj >>> 1) + 11'sd127;
              rem_nxt   = 27'd0;
              cnt_nxt   = 6'd23;
              state_nxt = F_SQRT;
            end
            default: state_nxt = F_IDLE;
          endcase
        end
      end
      // bring subnormal divide operands to a leading one
      F_PREN: begin
        if (!ma_r[23]) begin
          ma_nxt = {ma_r[22:0], 1'b0};
          ea_nxt = ea_r - 11'sd1;
        end else if (!mb_r[23]) begin
          mb_nxt = {mb_r[22:0], 1'b0};
          eb_nxt = eb_r - 11'sd1;
        end else begin
          rem_nxt   = {3'b000, ma_r};
          e_nxt     = ea_r - eb_r + 11'sd127;
          cnt_nxt   = 6'd27;
          state_nxt = F_DIV;
        end
      end
      // shift-add multiply, multiplier bit from the low end
      F_MUL: begin
        r_nxt   = {mul_sum, r_r[25:3], 2'b00};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          state_nxt = F_NORM;
        end
      end
      // restoring divide, one quotient bit per cycle
      F_DIV: begin
        q_nxt   = {q_r[25:0], div_ge};
        rem_nxt = {div_rem[25:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          r_nxt     = {1'b0, q_r[26:0], div_ge, 21'd0};
          s_nxt     = |div_rem;
          state_nxt = F_NORM;
        end
      end
      // align the smaller addend with sticky collection, then add
      F_ALIGN: begin
        if (cnt_r == 6'd0 || sm_r == 50'd0) begin
          r_nxt     = r_r + sm_r;
          state_nxt = F_NORM;
        end else begin
          sm_nxt  = {1'b0, sm_r[49:1]};
          s_nxt   = s_r | sm_r[0];
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      // digit recurrence square root, two radicand bits per cycle
      F_SQRT: begin
        q_nxt   = {3'b000, sq_root};
        rem_nxt = sq_rem;
        n_nxt   = {n_r[45:0], 2'b00};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          // remainder above root means the exact root lies past the half
          r_nxt     = {1'b0, sq_root, sq_rem > {3'b000, sq_root}, 24'd0};
          s_nxt     = sq_rem > {3'b000, sq_root};
          state_nxt = F_NORM;
        end
      end
      // one-bit normalize steps
      F_NORM: begin
        if (r_r[49]) begin
          r_nxt = {1'b0, r_r[49:1]};
          s_nxt = s_r | r_r[0];
          e_nxt = e_r + 11'sd1;
        end else if (r_r == 50'd0) begin
          e_nxt     = 11'sd1;
          state_nxt = F_ROUND;
        end else if (!r_r[48]) begin
          r_nxt = {r_r[48:0], 1'b0};
          e_nxt = e_r - 11'sd1;
        end else begin
          state_nxt = F_DENORM;
        end
      end
      // shift down into the subnormal range
      F_DENORM: begin
        if (e_r < 11'sd1) begin
          if (r_r == 50'd0) begin
            e_nxt = 11'sd1;
          end else begin
            r_nxt = {1'b0, r_r[49:1]};
            s_nxt = s_r | r_r[0];
            e_nxt = e_r + 11'sd1;
          end
        end else begin
          state_nxt = F_ROUND;
        end
      end
      F_ROUND: begin
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    ea_r  <= ea_nxt;
    eb_r  <= eb_nxt;
    r_r   <= r_nxt;
    sm_r  <= sm_nxt;
    e_r   <= e_nxt;
    s_r   <= s_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    n_r   <= n_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

FILE: hdl/scaled_euclidean_norm.sv
// ----------------------------------------------------------------------------
// scaled_euclidean_norm: streaming bf16 vector norm
// Running scale in bf16 and scaled sum of squares in fp32, final scale * sqrt(sum)
// rounded to bf16.
//
//   channel   direction  signals
//   in_       input      in_valid/in_ready, element_bits, last_element,
//                        empty_vector
//   out_      output     out_valid/out_ready, norm_bits
//
// One element at a time. A zero, NaN, first nonzero or infinite element, or
// any after a NaN or an infinite scale, only updates the registers; any other
// takes a divide, one or two multiplies and an add. The last element adds the
// special-result check and, for a finite nonzero scale, a square root and a
// multiply. Synchronous reset; a result waits in the output register and the
// sequencer stalls only when a second result is due before it leaves.
// ----------------------------------------------------------------------------
module scaled_euclidean_norm import sen_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_element_bits,
  input  logic        in_last_element,
  input  logic        in_empty_vector,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_norm_bits
);

  seq_state_t  state_r, state_nxt;
  logic [14:0] scale_r, scale_nxt;
  logic [31:0] ssq_r, ssq_nxt;
  logic        nan_r, nan_nxt;
  logic [31:0] tmp_r, tmp_nxt;
  logic [14:0] a_r, a_nxt;
  logic        grow_r, grow_nxt;
  logic        last_r, last_nxt;
  logic        wait_r, wait_nxt;
  logic [15:0] res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_bits_r, out_bits_nxt;

  logic        fpu_start, fpu_done;
  fpu_cmd_t    fpu_cmd;
  logic [31:0] fpu_res;

  logic        in_fire;
  logic [14:0] elem;
  logic        elem_nan, elem_inf, scale_inf, op_state;
  logic [31:0] scale_fp, a_fp, bf_sum;

  sen_fpu u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (fpu_start),
    .cmd    (fpu_cmd),
    .done   (fpu_done),
    .result (fpu_res)
  );

  // element classification
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    in_fire   = in_valid & in_ready;
    elem      = in_element_bits[14:0];
    elem_nan  = (elem[14:7] == 8'hFF) && (elem[6:0] != 7'd0);
    elem_inf  = (elem == BF_INF[14:0]);
    scale_inf = (scale_r == BF_INF[14:0]);
    scale_fp  = {1'b0, scale_r, 16'd0};
    a_fp      = {1'b0, a_r, 16'd0};
    bf_sum    = fpu_res + 32'h0000_7FFF + {31'd0, fpu_res[16]};
    op_state  = (state_r == S_DIV) || (state_r == S_SQ) || (state_r == S_PROD) ||
                (state_r == S_ACC) || (state_r == S_ROOT) || (state_r == S_SCALE);
    fpu_start = op_state & ~wait_r;
  end

  // arithmetic command per sequencer step
  always_comb begin
    fpu_cmd.op = FOP_MUL;
    fpu_cmd.a  = tmp_r;
    fpu_cmd.b  = tmp_r;
    case (state_r)
      S_DIV: begin
        fpu_cmd.op = FOP_DIV;
        fpu_cmd.a  = grow_r ? scale_fp : a_fp;
        fpu_cmd.b  = grow_r ? a_fp : scale_fp;
      end
      S_SQ: begin
        fpu_cmd.op = FOP_MUL;
      end
      S_PROD: begin
        fpu_cmd.op = FOP_MUL;
        fpu_cmd.a  = ssq_r;
      end
      S_ACC: begin
        fpu_cmd.op = FOP_ADD;
        fpu_cmd.a  = grow_r ? FP_ONE : ssq_r;
      end
      S_ROOT: begin
        fpu_cmd.op = FOP_SQRT;
        fpu_cmd.a  = ssq_r;
      end
      S_SCALE: begin
        fpu_cmd.op = FOP_MUL;
        fpu_cmd.a  = scale_fp;
      end
      default: fpu_cmd.op = FOP_MUL;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    scale_nxt     = scale_r;
    ssq_nxt       = ssq_r;
    nan_nxt       = nan_r;
    tmp_nxt       = tmp_r;
    a_nxt         = a_r;
    grow_nxt      = grow_r;
    last_nxt      = last_r;
    res_nxt       = res_r;
    wait_nxt      = wait_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_bits_nxt  = out_bits_r;
    if (fpu_start) begin
      wait_nxt = 1'b1;
    end
    if (fpu_done) begin
      wait_nxt = 1'b0;
      tmp_nxt  = fpu_res;
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          last_nxt = in_last_element;
          a_nxt    = elem;
          if (in_empty_vector) begin
            res_nxt   = BF_ZERO;
            state_nxt = S_OUT;
          end else begin
            state_nxt = in_last_element ? S_FIN : S_IDLE;
            if (elem == 15'd0) begin
              // zero element leaves the sums alone
            end else if (elem_nan) begin
              nan_nxt = 1'b1;
            end else if (scale_r < elem) begin
              // new largest magnitude
              if (nan_r || scale_r == 15'd0 || elem_inf) begin
                ssq_nxt   = FP_ONE;
                scale_nxt = elem;
              end else begin
                grow_nxt  = 1'b1;
                state_nxt = S_DIV;
              end
            end else if (nan_r) begin
              // sum already invalid
            end else if (scale_inf) begin
              nan_nxt = elem_inf;
            end else begin
              grow_nxt  = 1'b0;
              state_nxt = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (fpu_done) begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        if (fpu_done) begin
          state_nxt = grow_r ? S_PROD : S_ACC;
        end
      end
      S_PROD: begin
        if (fpu_done) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (fpu_done) begin
          ssq_nxt = fpu_res;
          if (grow_r) begin
            scale_nxt = a_r;
          end
          state_nxt = last_r ? S_FIN : S_IDLE;
        end
      end
      // special results of the final step
      S_FIN: begin
        if (nan_r) begin
          res_nxt   = BF_QNAN;
          state_nxt = S_OUT;
        end else if (scale_r == 15'd0) begin
          res_nxt   = BF_ZERO;
          state_nxt = S_OUT;
        end else if (scale_inf) begin
          res_nxt   = BF_INF;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (fpu_done) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        if (fpu_done) begin
          res_nxt   = bf_sum[31:16];
          state_nxt = S_OUT;
        end
      end
      // hand the result over and start a fresh vector
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_bits_nxt  = res_r;
          scale_nxt     = 15'd0;
          ssq_nxt       = FP_ONE;
          nan_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scale_r     <= 15'd0;
      ssq_r       <= FP_ONE;
      nan_r       <= 1'b0;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scale_r     <= scale_nxt;
      ssq_r       <= ssq_nxt;
      nan_r       <= nan_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tmp_r      <= tmp_nxt;
    a_r        <= a_nxt;
    grow_r     <= grow_nxt;
    last_r     <= last_nxt;
    res_r      <= res_nxt;
    out_bits_r <= out_bits_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_norm_bits = out_bits_r;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the scaled euclidean norm block
// Streams bf16 vectors into the block under random idling on both sides.
// An fp32 scaled sum-of-squares predictor computes the expected norm of
// every vector, and each result transaction is checked against it in order.
// ----------------------------------------------------------------------------
module tb import sen_pkg::*; ();

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_element_bits;
  logic        in_last_element;
  logic        in_empty_vector;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_norm_bits;

  // predictor state: fp32 bit patterns
  logic [31:0] scale_q;
  logic [31:0] sumsq_q;

  logic [15:0] norm_queue[$];
  int          errors = 0;
  bit          no_idle;

  scaled_euclidean_norm i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_element_bits (in_element_bits),
    .in_last_element (in_last_element),
    .in_empty_vector (in_empty_vector),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_norm_bits   (out_norm_bits)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // fp32 bits to real, exact
  function automatic real fp_to_real(logic [31:0] f);
    logic [63:0] d;
    real         r;
    if (f[30:23] == 8'hFF) begin
      d = {f[31], 11'h7FF, f[22:0], 29'b0};
      return $bitstoreal(d);
    end
    if (f[30:23] == 8'h00) begin
      r = real'(f[22:0]) * (2.0 ** -149);
      return f[31] ? -r : r;
    end
    d = {f[31], 11'(f[30:23] - 127 + 1023), f[22:0], 29'b0};
    return $bitstoreal(d);
  endfunction

  // real to fp32 bits, round to nearest even, with subnormals and overflow
  function automatic logic [31:0] real_to_fp(real r);
    logic [63:0] d;
    logic [63:0] mant;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] res;
    int          ef;
    int          sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF)
      return (d[51:0] != 0) ? 32'h7FC0_0000 : {d[63], 31'h7F80_0000};
    if (d[62:52] == 11'h000)
      return {d[63], 31'b0};
    ef   = int'(d[62:52]) - 1023 + 127;
    mant = {12'd1, d[51:0]};
    sh   = (ef >= 1) ? 29 : 29 + (1 - ef);
    if (sh > 60)
      sh = 60;
    q    = mant >> sh;
    half = 64'd1 << (sh - 1);
    rem  = mant & ((64'd1 << sh) - 1);
    if (rem > half || (rem == half && q[0]))
      q = q + 1;
    if (ef >= 1)
      res = (64'(ef - 1) << 23) + q;
    else
      res = q;
    if (res >= 64'h7F80_0000)
      res = 64'h7F80_0000;
    return {d[63], res[30:0]};
  endfunction

  // advance the norm state by one element, queue the norm when one is due
  function automatic void norm_update(logic [15:0] eb, logic last, logic empty);
    logic [31:0] mag;
    logic [31:0] t;
    logic [31:0] sq;
    logic [31:0] root;
    logic [31:0] nrm;
    logic [31:0] u;
    if (empty) begin
      norm_queue.push_back(BF_ZERO);
      scale_q = FP_ZERO;
      sumsq_q = FP_ONE;
      return;
    end
    if (eb[14:0] != 0) begin
      mag = {1'b0, eb[14:0], 16'b0};
      if (mag[30:23] == 8'hFF && mag[22:0] != 0) begin
        sumsq_q = mag;
      end else if (fp_to_real(scale_q) < fp_to_real(mag)) begin
        t  = real_to_fp(fp_to_real(scale_q) / fp_to_real(mag));
        sq = real_to_fp(fp_to_real(t) * fp_to_real(t));
        sq = real_to_fp(fp_to_real(sumsq_q) * fp_to_real(sq));
        sumsq_q = real_to_fp(fp_to_real(sq) + 1.0);
        scale_q = mag;
      end else begin
        t  = real_to_fp(fp_to_real(mag) / fp_to_real(scale_q));
        sq = real_to_fp(fp_to_real(t) * fp_to_real(t));
        sumsq_q = real_to_fp(fp_to_real(sumsq_q) + fp_to_real(sq));
      end
    end
    if (last) begin
      root = real_to_fp($sqrt(fp_to_real(sumsq_q)));
      nrm  = real_to_fp(fp_to_real(scale_q) * fp_to_real(root));
      if (nrm[30:23] == 8'hFF && nrm[22:0] != 0) begin
        norm_queue.push_back(BF_QNAN);
      end else begin
        u = nrm + 32'h7FFF + {31'd0, nrm[16]};
        norm_queue.push_back(u[31:16]);
      end
      scale_q = FP_ZERO;
      sumsq_q = FP_ONE;
    end
  endfunction

  // send one transaction, with an occasional random gap before it
  task automatic send_element(logic [15:0] eb, logic last, logic empty);
    int gap;
    if (!no_idle && $urandom_range(99) < 12) begin
      gap = $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_element_bits <= eb;
    in_last_element <= last;
    in_empty_vector <= empty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    norm_update(eb, last, empty);
  endtask

  // hold the sender until every pending norm has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (norm_queue.size() != 0) @(posedge clk);
  endtask

  // random bf16 element: mostly finite with spread exponents
  function automatic logic [15:0] rand_element();
    logic [15:0] e;
    int          k;
    e = 16'($urandom);
    k = $urandom_range(99);
    if (k < 70)
      e[14:7] = 8'($urandom_range(200, 60));
    else if (k < 76)
      e[14:7] = 8'h00;
    else if (k < 79)
      e[14:0] = 15'h0;
    else if (k < 81)
      e[14:7] = 8'hFF;
    return e;
  endfunction

  // special cases and extremes
  task automatic test_specials();
    send_element(16'h0000, 1'b0, 1'b1);        // empty vector
    send_element(16'hFFFF, 1'b1, 1'b1);        // empty wins over last
    send_element(16'h3F80, 1'b1, 1'b0);        // single element
    send_element(16'hC040, 1'b1, 1'b0);        // single negative element
    send_element(16'h8000, 1'b0, 1'b0);        // negative zero skipped
    send_element(16'h0000, 1'b1, 1'b0);        // all-zero vector
    send_element(16'h4040, 1'b0, 1'b0);        // 3,4 -> 5
    send_element(16'h4080, 1'b1, 1'b0);
    send_element(16'h7F7F, 1'b0, 1'b0);        // overflow of the product
    send_element(16'hFF7F, 1'b1, 1'b0);
    send_element(16'h0001, 1'b0, 1'b0);        // subnormals
    send_element(16'h807F, 1'b1, 1'b0);
    send_element(16'h7FC1, 1'b0, 1'b0);        // nan element
    send_element(16'h3F80, 1'b1, 1'b0);
    send_element(16'h7F80, 1'b0, 1'b0);        // infinity then finite
    send_element(16'h4000, 1'b1, 1'b0);
    send_element(16'h7F80, 1'b0, 1'b0);        // two infinities
    send_element(16'hFF80, 1'b1, 1'b0);
    send_element(16'h4000, 1'b0, 1'b0);        // empty drops a partial sum
    send_element(16'h5555, 1'b0, 1'b1);
    send_element(16'h2AAA, 1'b1, 1'b0);
    send_element(16'h0080, 1'b0, 1'b0);        // smallest normal, larger later
    send_element(16'h7F00, 1'b1, 1'b0);
  endtask

  // random vectors of small length, with some noise
  task automatic test_random_vectors(int count);
    int sent;
    int len;
    int k;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
      for (k = 0; k < len && sent < count; k++) begin
        sent++;
        if ($urandom_range(49) == 0)
          send_element(16'($urandom), 1'($urandom), 1'b1);
        else
          send_element(rand_element(), (k == len - 1), 1'b0);
      end
      if ($urandom_range(39) == 0)
        drain_results();
    end
  endtask

  // stimulus
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_element_bits = '0;
    in_last_element = 1'b0;
    in_empty_vector = 1'b0;
    no_idle         = 1'b0;
    scale_q         = FP_ZERO;
    sumsq_q         = FP_ONE;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_specials();
    drain_results();
    test_random_vectors(700);
    no_idle = 1'b1;
    test_random_vectors(250);
    no_idle = 1'b0;
    drain_results();
    test_random_vectors(500);
    in_valid <= 1'b0;
    while (norm_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0)
      $display("scaled_euclidean_norm: match");
    else
      $display("scaled_euclidean_norm: mismatch");
    $finish;
  end

  // receiver readiness
  always @(posedge clk) begin
    if (!rst_n)
      out_ready <= 1'b0;
    else
      out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 12);
  end

  // check each result transaction against the oldest expected norm
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (norm_queue.size() == 0) begin
        $error("norm_bits: unexpected result %h", out_norm_bits);
        errors++;
      end else begin
        if (out_norm_bits !== norm_queue[0]) begin
          $error("norm_bits: expected %h actual %h", norm_queue[0], out_norm_bits);
          errors++;
        end
        void'(norm_queue.pop_front());
      end
    end
  end

  // timeout
  initial begin
    #(12 * 4_000_000);
    $display("scaled_euclidean_norm: mismatch");
    $finish;
  end

endmodule

FILE: files.f
hdl/sen_pkg.sv
hdl/sen_fpu.sv
hdl/scaled_euclidean_norm.sv
tb/tb.sv
